// ----- design/source_tokenizer_assert.svh -----
// ---------------------------------------------------------------------------
// source_tokenizer_assert.svh
// Assertion macros shared by the tokenizer's checkers.
// ---------------------------------------------------------------------------
// Both macros expect clk and rst_n in scope.
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define ST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("source_tokenizer check failed");

// Next-cycle implication.
`define ST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("source_tokenizer check failed");

`endif

// ----- design/st_pkg.sv -----
// ---------------------------------------------------------------------------
// st_pkg
// Types, codes and character tables of the source tokenizer.
// ---------------------------------------------------------------------------
package st_pkg;

  localparam int COORD_BITS  = 16;
  localparam int OFFSET_BITS = 24;
  localparam int KIND_BITS   = 6;
  localparam int ERR_BITS    = 2;
  localparam int EOF_LEN     = 3;

  // token kinds
  localparam logic [KIND_BITS-1:0] KIND_IDENT   = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_INT     = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_STR     = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_EOF     = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 6'd4;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 6'd5;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 6'd6;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 6'd7;
  localparam logic [KIND_BITS-1:0] KIND_LBRACK  = 6'd8;
  localparam logic [KIND_BITS-1:0] KIND_RBRACK  = 6'd9;
  localparam logic [KIND_BITS-1:0] KIND_COLON   = 6'd10;
  localparam logic [KIND_BITS-1:0] KIND_BANG    = 6'd11;
  localparam logic [KIND_BITS-1:0] KIND_SEMI    = 6'd12;
  localparam logic [KIND_BITS-1:0] KIND_PLUS    = 6'd13;
  localparam logic [KIND_BITS-1:0] KIND_MINUS   = 6'd14;
  localparam logic [KIND_BITS-1:0] KIND_SLASH   = 6'd15;
  localparam logic [KIND_BITS-1:0] KIND_PCT     = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_STAR    = 6'd17;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_ADD_EQ  = 6'd19;
  localparam logic [KIND_BITS-1:0] KIND_SUB_EQ  = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_DIV_EQ  = 6'd21;
  localparam logic [KIND_BITS-1:0] KIND_MUL_EQ  = 6'd22;
  localparam logic [KIND_BITS-1:0] KIND_AMP     = 6'd23;
  localparam logic [KIND_BITS-1:0] KIND_BAR     = 6'd24;
  localparam logic [KIND_BITS-1:0] KIND_LAND    = 6'd25;
  localparam logic [KIND_BITS-1:0] KIND_LOR     = 6'd26;
  localparam logic [KIND_BITS-1:0] KIND_AND_EQ  = 6'd27;
  localparam logic [KIND_BITS-1:0] KIND_OR_EQ   = 6'd28;
  localparam logic [KIND_BITS-1:0] KIND_CARET   = 6'd29;
  localparam logic [KIND_BITS-1:0] KIND_XOR_EQ  = 6'd30;
  localparam logic [KIND_BITS-1:0] KIND_GT      = 6'd31;
  localparam logic [KIND_BITS-1:0] KIND_LT      = 6'd32;
  localparam logic [KIND_BITS-1:0] KIND_GE      = 6'd33;
  localparam logic [KIND_BITS-1:0] KIND_LE      = 6'd34;
  // no operator; operator kinds never take this value
  localparam logic [KIND_BITS-1:0] KIND_NONE    = 6'd0;

  // error codes
  localparam logic [ERR_BITS-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_DMINUS  = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_QUOTE   = 2'd3;

  // characters with a role of their own
  localparam logic [7:0] CH_NONE   = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_STR
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_source;
  } in_word_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [ERR_BITS-1:0]    err;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [COORD_BITS-1:0]  start_row;
    logic [COORD_BITS-1:0]  start_col;
    logic [COORD_BITS-1:0]  tok_len;
    logic                   last_of_run;
  } out_word_t;

  // up to two results from one input word, packed from w0
  typedef struct packed {
    logic      vld0;
    logic      vld1;
    out_word_t w0;
    out_word_t w1;
  } res_pair_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c == CH_UNDER) || is_alpha(c) || is_digit(c);
  endfunction

  // one-character operators, KIND_NONE if not one
  function automatic logic [KIND_BITS-1:0] single_kind(logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      8'h28:   k = KIND_LPAREN;  // (
      8'h29:   k = KIND_RPAREN;  // )
      8'h7B:   k = KIND_LBRACE;  // {
      8'h7D:   k = KIND_RBRACE;  // }
      8'h5B:   k = KIND_LBRACK;  // [
      8'h5D:   k = KIND_RBRACK;  // ]
      8'h3A:   k = KIND_COLON;   // :
      8'h21:   k = KIND_BANG;    // !
      8'h3B:   k = KIND_SEMI;    // ;
      8'h2B:   k = KIND_PLUS;    // +
      8'h2D:   k = KIND_MINUS;   // -
      8'h2F:   k = KIND_SLASH;   // /
      8'h25:   k = KIND_PCT;     // %
      8'h2A:   k = KIND_STAR;    // *
      8'h3D:   k = KIND_ASSIGN;  // =
      8'h26:   k = KIND_AMP;     // &
      8'h7C:   k = KIND_BAR;     // |
      8'h5E:   k = KIND_CARET;   // ^
      8'h3E:   k = KIND_GT;      // >
      8'h3C:   k = KIND_LT;      // <
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // two-character operators, KIND_NONE if the pair is none
  function automatic logic [KIND_BITS-1:0] pair_kind(logic [7:0] a, logic [7:0] b);
    logic [KIND_BITS-1:0] k;
    k = KIND_NONE;
    if (b == 8'h3D) begin
      case (a)
        8'h2B:   k = KIND_ADD_EQ;
        8'h2D:   k = KIND_SUB_EQ;
        8'h2F:   k = KIND_DIV_EQ;
        8'h2A:   k = KIND_MUL_EQ;
        8'h26:   k = KIND_AND_EQ;
        8'h7C:   k = KIND_OR_EQ;
        8'h5E:   k = KIND_XOR_EQ;
        8'h3E:   k = KIND_GE;
        8'h3C:   k = KIND_LE;
        default: k = KIND_NONE;
      endcase
    end else if ((a == 8'h26) && (b == 8'h26)) begin
      k = KIND_LAND;
    end else if ((a == 8'h7C) && (b == 8'h7C)) begin
      k = KIND_LOR;
    end
    return k;
  endfunction

  function automatic out_word_t make_word(
    logic [KIND_BITS-1:0]   kind,
    logic [ERR_BITS-1:0]    err,
    logic [OFFSET_BITS-1:0] off,
    logic [COORD_BITS-1:0]  row,
    logic [COORD_BITS-1:0]  col,
    logic [COORD_BITS-1:0]  len
  );
    out_word_t w;
    w.kind         = kind;
    w.err          = err;
    w.start_offset = off;
    w.start_row    = row;
    w.start_col    = col;
    w.tok_len      = len;
    w.last_of_run  = 1'b0;
    return w;
  endfunction

endpackage

// ----- design/st_core.sv -----
// ---------------------------------------------------------------------------
// st_core
// Scan state and per-byte token decision; yields up to two results a word.
// ---------------------------------------------------------------------------
module st_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  st_pkg::in_word_t   in_w,
  output st_pkg::res_pair_t  res
);
  import st_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int OB = OFFSET_BITS;

  scan_mode_t     mode_r, mode_nxt;
  logic [CB-1:0]  cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [OB-1:0]  cur_off_r, cur_off_nxt;
  logic [CB-1:0]  tok_row_r, tok_row_nxt, tok_col_r, tok_col_nxt;
  logic [OB-1:0]  tok_off_r, tok_off_nxt;
  logic [CB-1:0]  tok_cnt_r, tok_cnt_nxt;
  logic [7:0]     pend_r, pend_nxt;
  logic           halt_r, halt_nxt;

  logic [7:0]     c;
  logic           eos, live, pend_on, dminus, member, run_mode;
  logic [CB-1:0]  col_inc, row_inc, cnt_inc, eof_col;
  logic [OB-1:0]  off_inc;
  logic [KIND_BITS-1:0] pk, sk_pend, run_kind;

  // decode of a byte that starts fresh
  logic           f_emit, f_halt;
  logic [ERR_BITS-1:0] f_err;
  scan_mode_t     f_mode;
  logic [7:0]     f_pend;
  logic [CB-1:0]  f_row, f_col, f_trow, f_tcol, f_tcnt;
  logic [OB-1:0]  f_off, f_toff;

  out_word_t      w0, w1, f_word, eof_word;
  logic           v0, v1;

  assign c        = in_w.ch;
  assign eos      = in_w.end_of_source;
  assign live     = acc && !halt_r;
  assign pend_on  = (pend_r != CH_NONE);
  assign dminus   = (pend_r == CH_MINUS) && (c == CH_MINUS);
  assign pk       = pair_kind(pend_r, c);
  assign sk_pend  = single_kind(pend_r);
  assign run_mode = (mode_r == MODE_IDENT) || (mode_r == MODE_INT);
  assign member   = (mode_r == MODE_IDENT) ? is_word(c) : is_digit(c);
  assign run_kind = (mode_r == MODE_INT) ? KIND_INT :
                    (mode_r == MODE_STR) ? KIND_STR : KIND_IDENT;

  assign col_inc  = (cur_col_r == '1) ? cur_col_r : cur_col_r + CB'(1);
  assign row_inc  = (cur_row_r == '1) ? cur_row_r : cur_row_r + CB'(1);
  assign cnt_inc  = (tok_cnt_r == '1) ? tok_cnt_r : tok_cnt_r + CB'(1);
  assign off_inc  = cur_off_r + OB'(1);
  // an open string is closed implicitly at end of source
  assign eof_col  = (mode_r == MODE_STR) ? col_inc : cur_col_r;

  always_comb begin
    f_emit = 1'b0;
    f_halt = 1'b0;
    f_err  = ERR_NONE;
    f_mode = MODE_IDLE;
    f_pend = CH_NONE;
    f_row  = cur_row_r;
    f_col  = cur_col_r;
    f_off  = cur_off_r;
    f_trow = tok_row_r;
    f_tcol = tok_col_r;
    f_toff = tok_off_r;
    f_tcnt = tok_cnt_r;
    if (c == CH_NL) begin
      f_row = row_inc;
      f_col = CB'(1);
      f_off = off_inc;
    end else if ((c == CH_SPACE) || (c == CH_TAB)) begin
      f_col = col_inc;
      f_off = off_inc;
    end else if (c == CH_APOS) begin
      f_emit = 1'b1;
      f_err  = ERR_QUOTE;
      f_halt = 1'b1;
    end else if (c == CH_DQUOTE) begin
      f_trow = cur_row_r;
      f_tcol = cur_col_r;
      f_toff = off_inc;          // content starts after the quote
      f_tcnt = '0;
      f_mode = MODE_STR;
      f_col  = col_inc;
      f_off  = off_inc;
    end else if (is_word(c)) begin
      f_trow = cur_row_r;
      f_tcol = cur_col_r;
      f_toff = cur_off_r;
      f_tcnt = CB'(1);
      f_mode = is_digit(c) ? MODE_INT : MODE_IDENT;
      f_col  = col_inc;
      f_off  = off_inc;
    end else if (single_kind(c) != KIND_NONE) begin
      f_trow = cur_row_r;
      f_tcol = cur_col_r;
      f_toff = cur_off_r;
      f_pend = c;
      f_col  = col_inc;
      f_off  = off_inc;
    end else begin
      f_emit = 1'b1;
      f_err  = ERR_UNKNOWN;
      f_halt = 1'b1;
    end
  end

  // next state
  always_comb begin
    mode_nxt    = mode_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    cur_off_nxt = cur_off_r;
    tok_row_nxt = tok_row_r;
    tok_col_nxt = tok_col_r;
    tok_off_nxt = tok_off_r;
    tok_cnt_nxt = tok_cnt_r;
    pend_nxt    = pend_r;
    halt_nxt    = halt_r;
    if (live) begin
      if (eos) begin
        mode_nxt    = MODE_IDLE;
        cur_row_nxt = CB'(1);
        cur_col_nxt = CB'(1);
        cur_off_nxt = '0;
        tok_row_nxt = CB'(1);
        tok_col_nxt = CB'(1);
        tok_off_nxt = '0;
        tok_cnt_nxt = '0;
        pend_nxt    = CH_NONE;
        halt_nxt    = 1'b0;
      end else if (pend_on && dminus) begin
        halt_nxt = 1'b1;
      end else if (pend_on && (pk != KIND_NONE)) begin
        pend_nxt    = CH_NONE;
        cur_col_nxt = col_inc;
        cur_off_nxt = off_inc;
      end else if (!pend_on && (mode_r == MODE_STR)) begin
        if (c == CH_DQUOTE) begin
          mode_nxt = MODE_IDLE;
        end else begin
          tok_cnt_nxt = cnt_inc;
        end
        cur_col_nxt = col_inc;
        cur_off_nxt = off_inc;
      end else if (!pend_on && run_mode && member) begin
        tok_cnt_nxt = cnt_inc;
        cur_col_nxt = col_inc;
        cur_off_nxt = off_inc;
      end else begin
        mode_nxt    = f_mode;
        pend_nxt    = f_pend;
        halt_nxt    = f_halt;
        cur_row_nxt = f_row;
        cur_col_nxt = f_col;
        cur_off_nxt = f_off;
        tok_row_nxt = f_trow;
        tok_col_nxt = f_tcol;
        tok_off_nxt = f_toff;
        tok_cnt_nxt = f_tcnt;
      end
    end
  end

  // results
  always_comb begin
    f_word   = make_word(KIND_IDENT, f_err, cur_off_r, cur_row_r, cur_col_r, '0);
    eof_word = make_word(KIND_EOF, ERR_NONE, cur_off_r, cur_row_r, eof_col, CB'(EOF_LEN));
    w0 = eof_word;
    w1 = eof_word;
    v0 = 1'b0;
    v1 = 1'b0;
    if (live) begin
      if (eos) begin
        if (pend_on) begin
          w0 = make_word(sk_pend, ERR_NONE, tok_off_r, tok_row_r, tok_col_r, CB'(1));
          v0 = 1'b1;
          v1 = 1'b1;
        end else if (mode_r != MODE_IDLE) begin
          w0 = make_word(run_kind, ERR_NONE, tok_off_r, tok_row_r, tok_col_r, tok_cnt_r);
          v0 = 1'b1;
          v1 = 1'b1;
        end else begin
          v0 = 1'b1;
        end
      end else if (pend_on) begin
        v0 = 1'b1;
        if (dminus) begin
          w0 = make_word(KIND_IDENT, ERR_DMINUS, tok_off_r, tok_row_r, tok_col_r, '0);
        end else if (pk != KIND_NONE) begin
          w0 = make_word(pk, ERR_NONE, tok_off_r, tok_row_r, tok_col_r, CB'(2));
        end else begin
          w0 = make_word(sk_pend, ERR_NONE, tok_off_r, tok_row_r, tok_col_r, CB'(1));
          w1 = f_word;
          v1 = f_emit;
        end
      end else if (mode_r == MODE_STR) begin
        w0 = make_word(KIND_STR, ERR_NONE, tok_off_r, tok_row_r, tok_col_r, tok_cnt_r);
        v0 = (c == CH_DQUOTE);
      end else if (run_mode) begin
        if (!member) begin
          w0 = make_word(run_kind, ERR_NONE, tok_off_r, tok_row_r, tok_col_r, tok_cnt_r);
          v0 = 1'b1;
          w1 = f_word;
          v1 = f_emit;
        end
      end else begin
        w0 = f_word;
        v0 = f_emit;
      end
    end
    w0.last_of_run = !v1;
    w1.last_of_run = 1'b1;
    res.vld0 = v0;
    res.vld1 = v1;
    res.w0   = w0;
    res.w1   = w1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      cur_row_r <= CB'(1);
      cur_col_r <= CB'(1);
      cur_off_r <= '0;
      tok_row_r <= CB'(1);
      tok_col_r <= CB'(1);
      tok_off_r <= '0;
      tok_cnt_r <= '0;
      pend_r    <= CH_NONE;
      halt_r    <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      cur_off_r <= cur_off_nxt;
      tok_row_r <= tok_row_nxt;
      tok_col_r <= tok_col_nxt;
      tok_off_r <= tok_off_nxt;
      tok_cnt_r <= tok_cnt_nxt;
      pend_r    <= pend_nxt;
      halt_r    <= halt_nxt;
    end
  end

endmodule

// ----- design/st_outq.sv -----
// ---------------------------------------------------------------------------
// st_outq
// Four-deep result queue: two writes and one read per cycle.
// ---------------------------------------------------------------------------
module st_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  st_pkg::res_pair_t  res,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output st_pkg::out_word_t  out_word
);
  import st_pkg::*;

  localparam int DEPTH = 4;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_word_t        ent_r   [DEPTH];
  out_word_t        ent_nxt [DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, base;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_word  = ent_r[0];
  // room for the worst case of two results
  assign space_ok  = (cnt_r <= CNT_W'(DEPTH - 2));
  assign pop       = out_valid && out_ready;
  assign base      = cnt_r - CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ent_nxt[i] = ent_r[i + 1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (res.vld0 && (base == CNT_W'(i))) begin
        ent_nxt[i] = res.w0;
      end
      if (res.vld1 && ((base + CNT_W'(1)) == CNT_W'(i))) begin
        ent_nxt[i] = res.w1;
      end
    end
    cnt_nxt = base + CNT_W'(res.vld0) + CNT_W'(res.vld1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- design/source_tokenizer.sv -----
// ---------------------------------------------------------------------------
// source_tokenizer
// Longest-match lexer: source bytes in, positioned tokens out.
// ---------------------------------------------------------------------------
// The tokenizer takes one source byte per input word and can accept a word
// every cycle while in_ready is high. Each word is decided in the cycle it
// is accepted by st_core, whose scan registers hold the open token, and its
// zero, one or two results land in a four-deep result queue that drives the
// output port directly. Results leave through the single result port of the
// queue, so words that yield two (a flushed token plus EOF, or a token plus
// an error) can fill it; in_ready drops while the queue holds more than two
// results. Operators wait for one byte of lookahead, so a one-byte operator,
// like an identifier or a number, is emitted on the word after its last
// byte or on the end word. Errors (an unknown byte, a double minus, an
// apostrophe) are reported once, after any token they close, and then words
// are still accepted but yield nothing until reset. Row, column and length
// saturate; offsets wrap.
// ---------------------------------------------------------------------------
module source_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  st_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output st_pkg::out_word_t out_word
);
  import st_pkg::*;

  res_pair_t res;
  logic      space_ok;
  logic      acc;

  // accept whenever the queue can absorb the worst case of this word
  assign in_ready = space_ok;
  assign acc      = in_valid && in_ready;

  // per-byte decision and scan state
  st_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .in_w  (in_word),
    .res   (res)
  );

  // result queue; also the output register
  st_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// ----- design/st_checker.sv -----
// ---------------------------------------------------------------------------
// st_checker
// Port-level checks of the tokenizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "source_tokenizer_assert.svh"

module st_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input st_pkg::in_word_t  in_word,
  input logic              out_valid,
  input logic              out_ready,
  input st_pkg::out_word_t out_word
);
  import st_pkg::*;

  // stalled input word holds
  `ST_ASSERT_NXT(a_in_hold, in_valid && !in_ready,
                 in_valid && $stable(in_word))

  // stalled result holds
  `ST_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                 out_valid && $stable(out_word))

  // EOF closes its word and carries the fixed length
  `ST_ASSERT_IMP(a_eof_shape, out_valid && (out_word.kind == KIND_EOF),
                 out_word.last_of_run && (out_word.err == ERR_NONE) &&
                 (out_word.tok_len == COORD_BITS'(EOF_LEN)))

  // an error is the final result of its word, zero length
  `ST_ASSERT_IMP(a_err_shape, out_valid && (out_word.err != ERR_NONE),
                 out_word.last_of_run && (out_word.kind == KIND_IDENT) &&
                 (out_word.tok_len == '0))

  // positions are one-based
  `ST_ASSERT_IMP(a_pos_nonzero, out_valid,
                 (out_word.start_row != '0) && (out_word.start_col != '0))

endmodule

bind source_tokenizer st_checker u_st_checker (.*);

// ----- bench/tb_source_tokenizer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_source_tokenizer
// Self-checking bench for the source tokenizer.
// ---------------------------------------------------------------------------
// Source text is built as a queue of words and pushed through the input
// channel. A scoreboard class holds a scan state of its own. It predicts the
// tokens of every accepted word and compares each accepted result with the
// oldest prediction, field by field. Both channels idle in short random
// bursts. The output side holds off once for a long stretch, so the result
// queue fills and the input stalls. The last part runs with no idling. The
// run ends on one error, because an error halts the block until the next
// reset.
// ---------------------------------------------------------------------------
module tb_source_tokenizer;
  import st_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int RANDOM_WORDS = 1400;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 40;

  // -------------------------------------------------------------------------
  // Scoreboard: scan state, token prediction and result comparison
  // -------------------------------------------------------------------------
  class token_scoreboard;
    scan_mode_t             mode;
    logic [COORD_BITS-1:0]  cur_row, cur_col, tok_row, tok_col, tok_len;
    logic [OFFSET_BITS-1:0] cur_off, tok_off;
    logic [7:0]             held_op;   // operator waiting for lookahead
    bit                     halted;
    out_word_t              due_tokens[$];
    out_word_t              this_run[$];
    int                     errors, checked, noted;

    function new();
      errors  = 0;
      checked = 0;
      noted   = 0;
      restart();
    endfunction

    function void restart();
      mode    = MODE_IDLE;
      cur_row = 1;
      cur_col = 1;
      cur_off = 0;
      tok_row = 1;
      tok_col = 1;
      tok_off = 0;
      tok_len = 0;
      held_op = CH_NONE;
      halted  = 1'b0;
    endfunction

    static function bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    static function bit numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    static function bit word_char(logic [7:0] c);
      return c == CH_UNDER || letter(c) || numeral(c);
    endfunction

    static function logic [KIND_BITS-1:0] op_single(logic [7:0] c);
      case (c)
        "(":     return KIND_LPAREN;
        ")":     return KIND_RPAREN;
        "{":     return KIND_LBRACE;
        "}":     return KIND_RBRACE;
        "[":     return KIND_LBRACK;
        "]":     return KIND_RBRACK;
        ":":     return KIND_COLON;
        "!":     return KIND_BANG;
        ";":     return KIND_SEMI;
        "+":     return KIND_PLUS;
        "-":     return KIND_MINUS;
        "/":     return KIND_SLASH;
        "%":     return KIND_PCT;
        "*":     return KIND_STAR;
        "=":     return KIND_ASSIGN;
        "&":     return KIND_AMP;
        "|":     return KIND_BAR;
        "^":     return KIND_CARET;
        ">":     return KIND_GT;
        "<":     return KIND_LT;
        default: return KIND_NONE;
      endcase
    endfunction

    static function logic [KIND_BITS-1:0] op_pair(logic [7:0] a, logic [7:0] b);
      if (b == "=") begin
        case (a)
          "+":     return KIND_ADD_EQ;
          "-":     return KIND_SUB_EQ;
          "/":     return KIND_DIV_EQ;
          "*":     return KIND_MUL_EQ;
          "&":     return KIND_AND_EQ;
          "|":     return KIND_OR_EQ;
          "^":     return KIND_XOR_EQ;
          ">":     return KIND_GE;
          "<":     return KIND_LE;
          default: return KIND_NONE;
        endcase
      end
      if (a == "&" && b == "&") return KIND_LAND;
      if (a == "|" && b == "|") return KIND_LOR;
      return KIND_NONE;
    endfunction

    // bytes that can stand outside a string without raising an error
    static function bit codeable(logic [7:0] c);
      return word_char(c) || op_single(c) != KIND_NONE ||
             c == CH_SPACE || c == CH_TAB || c == CH_NL;
    endfunction

    function logic [COORD_BITS-1:0] bump(logic [COORD_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void add(logic [KIND_BITS-1:0] kind, logic [ERR_BITS-1:0] err,
                      logic [OFFSET_BITS-1:0] off, logic [COORD_BITS-1:0] row,
                      logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] len);
      out_word_t w;
      w.kind         = kind;
      w.err          = err;
      w.start_offset = off;
      w.start_row    = row;
      w.start_col    = col;
      w.tok_len      = len;
      w.last_of_run  = 1'b0;
      if (this_run.size() < 2) this_run.push_back(w);
    endfunction

    function void step_col();
      cur_col = bump(cur_col);
      cur_off = cur_off + 1'b1;
    endfunction

    function void mark_token();
      tok_row = cur_row;
      tok_col = cur_col;
      tok_off = cur_off;
    endfunction

    // byte seen with no token open
    function void fresh_byte(logic [7:0] c);
      if (c == CH_NL) begin
        cur_row = bump(cur_row);
        cur_col = 1;
        cur_off = cur_off + 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB) begin
        step_col();
      end else if (c == CH_APOS) begin
        add(KIND_NONE, ERR_QUOTE, cur_off, cur_row, cur_col, 0);
        halted = 1'b1;
      end else if (c == CH_DQUOTE) begin
        mark_token();
        tok_off = cur_off + 1'b1;   // strings start at the content
        tok_len = 0;
        mode    = MODE_STR;
        step_col();
      end else if (word_char(c)) begin
        mark_token();
        tok_len = 1;
        mode    = numeral(c) ? MODE_INT : MODE_IDENT;
        step_col();
      end else if (op_single(c) != KIND_NONE) begin
        mark_token();
        held_op = c;
        step_col();
      end else begin
        add(KIND_NONE, ERR_UNKNOWN, cur_off, cur_row, cur_col, 0);
        halted = 1'b1;
      end
    endfunction

    function void flush_source();
      if (held_op != CH_NONE) begin
        add(op_single(held_op), ERR_NONE, tok_off, tok_row, tok_col, 1);
      end else begin
        case (mode)
          MODE_IDENT: add(KIND_IDENT, ERR_NONE, tok_off, tok_row, tok_col, tok_len);
          MODE_INT:   add(KIND_INT, ERR_NONE, tok_off, tok_row, tok_col, tok_len);
          MODE_STR: begin
            add(KIND_STR, ERR_NONE, tok_off, tok_row, tok_col, tok_len);
            cur_col = bump(cur_col);   // as if the closing quote were there
          end
          default: ;
        endcase
      end
      add(KIND_EOF, ERR_NONE, cur_off, cur_row, cur_col, COORD_BITS'(EOF_LEN));
      restart();
    endfunction

    function void scan_byte(logic [7:0] c);
      logic [KIND_BITS-1:0] k2;
      if (held_op != CH_NONE) begin
        k2 = op_pair(held_op, c);
        if (held_op == CH_MINUS && c == CH_MINUS) begin
          add(KIND_NONE, ERR_DMINUS, tok_off, tok_row, tok_col, 0);
          halted = 1'b1;
        end else if (k2 != KIND_NONE) begin
          add(k2, ERR_NONE, tok_off, tok_row, tok_col, 2);
          held_op = CH_NONE;
          step_col();
        end else begin
          add(op_single(held_op), ERR_NONE, tok_off, tok_row, tok_col, 1);
          held_op = CH_NONE;
          fresh_byte(c);
        end
      end else if (mode == MODE_STR) begin
        if (c == CH_DQUOTE) begin
          add(KIND_STR, ERR_NONE, tok_off, tok_row, tok_col, tok_len);
          mode = MODE_IDLE;
        end else begin
          tok_len = bump(tok_len);   // newline here is plain content
        end
        step_col();
      end else if (mode == MODE_IDENT || mode == MODE_INT) begin
        if ((mode == MODE_IDENT) ? word_char(c) : numeral(c)) begin
          tok_len = bump(tok_len);
          step_col();
        end else begin
          add((mode == MODE_IDENT) ? KIND_IDENT : KIND_INT, ERR_NONE,
              tok_off, tok_row, tok_col, tok_len);
          mode = MODE_IDLE;
          fresh_byte(c);
        end
      end else begin
        fresh_byte(c);
      end
    endfunction

    // accepted input word: predict its tokens
    function void note_word(in_word_t w);
      this_run.delete();
      noted++;
      if (halted) return;
      if (w.end_of_source) flush_source();
      else scan_byte(w.ch);
      if (this_run.size() > 0) this_run[this_run.size()-1].last_of_run = 1'b1;
      foreach (this_run[i]) due_tokens.push_back(this_run[i]);
    endfunction

    function void compare_field(string name, longint unsigned e, longint unsigned a);
      if (e == a) return;
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
    endfunction

    // accepted result word: compare with the oldest prediction
    function void check_word(out_word_t got);
      out_word_t exp;
      if (due_tokens.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual kind %0d offset %0d",
                   $time, got.kind, got.start_offset);
        return;
      end
      exp = due_tokens.pop_front();
      checked++;
      compare_field("kind", exp.kind, got.kind);
      compare_field("err", exp.err, got.err);
      compare_field("start_offset", exp.start_offset, got.start_offset);
      compare_field("start_row", exp.start_row, got.start_row);
      compare_field("start_col", exp.start_col, got.start_col);
      compare_field("tok_len", exp.tok_len, got.tok_len);
      compare_field("last_of_run", exp.last_of_run, got.last_of_run);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, DUT
  // -------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  always #5 clk = ~clk;

  source_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  token_scoreboard sb;
  bit              idle_on  = 1'b1;   // random idle bursts on both sides
  bit              hold_req = 1'b0;   // asks the receiver for one long hold-off
  int              cycle_cnt = 0;
  int              src_count = 0;
  int              words_sent = 0;
  logic [1:0]      finale_err;

  // Both handshakes are sampled at the same edge, in one process: the input
  // is noted before the output is checked, so ordering never matters.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_word);
      if (out_valid && out_ready) sb.check_word(out_word);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random short gaps, plus one long hold on request.
  initial begin : receiver
    int gap_left;
    int hold_left;
    bit hold_done;
    gap_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 5);   // start of an idle burst
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Source text builders
  // -------------------------------------------------------------------------
  in_word_t   src_q[$];
  logic [7:0] last_code = CH_NONE;   // last byte placed outside a string
  string      one_ops = "(){}[]:!;+-/%*=&|^><";
  string      two_ops = "+=-=/=*=&&||&=|=^=>=<=";

  function automatic void put_raw(logic [7:0] c);
    in_word_t w;
    w.ch            = c;
    w.end_of_source = 1'b0;
    src_q.push_back(w);
    last_code = CH_NONE;
  endfunction

  // a minus right after a minus would halt the block, so split them
  function automatic void put_code(logic [7:0] c);
    if (last_code == CH_MINUS && c == CH_MINUS) put_raw(CH_SPACE);
    put_raw(c);
    last_code = c;
  endfunction

  function automatic void put_end();
    in_word_t w;
    w.ch            = 8'($urandom_range(0, 255));   // ignored by the block
    w.end_of_source = 1'b1;
    src_q.push_back(w);
    last_code = CH_NONE;
    src_count++;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_raw(s[i]);
  endfunction

  // any byte but the double quote; newline and apostrophe come often
  function automatic logic [7:0] content_byte();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = CH_NL;
      1:       c = CH_APOS;
      default: begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_DQUOTE);
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (!token_scoreboard::codeable(c));
    return c;
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h30, 8'h7A)); while (!token_scoreboard::word_char(c));
    return c;
  endfunction

  function automatic logic [7:0] unknown_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (token_scoreboard::codeable(c) || c == CH_DQUOTE || c == CH_APOS);
    return c;
  endfunction

  function automatic void add_lexeme();
    int         r;
    int         idx;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      do c = word_byte(); while (token_scoreboard::numeral(c));
      put_code(c);
      repeat ($urandom_range(0, 7)) put_code(word_byte());
    end else if (r < 40) begin
      repeat ($urandom_range(1, 5)) put_code(8'h30 + 8'($urandom_range(0, 9)));
    end else if (r < 52) begin
      put_code(CH_DQUOTE);
      repeat ($urandom_range(0, 8)) put_raw(content_byte());
      put_code(CH_DQUOTE);
    end else if (r < 82) begin
      idx = $urandom_range(0, 30);
      if (idx < 20) begin
        put_code(one_ops[idx]);
      end else begin
        put_code(two_ops[2*(idx-20)]);
        put_code(two_ops[2*(idx-20)+1]);
      end
    end else if (r < 95) begin
      case ($urandom_range(0, 2))
        0:       put_code(CH_SPACE);
        1:       put_code(CH_TAB);
        default: put_code(CH_NL);
      endcase
    end else begin
      put_code(noise_byte());
    end
  endfunction

  // mostly well-formed lexemes; some raw noise, some open strings at the end
  function automatic void build_random_source();
    int n;
    n = $urandom_range(1, 12);
    if ($urandom_range(0, 15) == 0) n = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat (n) put_code(noise_byte());
    end else begin
      repeat (n) add_lexeme();
    end
    if ($urandom_range(0, 9) == 0) begin
      put_code(CH_DQUOTE);
      repeat ($urandom_range(0, 5)) put_raw(content_byte());
    end
    put_end();
  endfunction

  // one error, then words that must give nothing
  function automatic void build_finale();
    finale_err = 2'($urandom_range(1, 3));
    if ($urandom_range(0, 1)) add_lexeme();
    case (finale_err)
      ERR_UNKNOWN: put_raw(unknown_byte());
      ERR_DMINUS: begin
        put_raw(CH_MINUS);
        put_raw(CH_MINUS);
      end
      default:     put_raw(CH_APOS);
    endcase
    repeat (4) put_raw(8'($urandom_range(0, 255)));
    put_end();
    put_raw(CH_APOS);
    put_end();
  endfunction

  // -------------------------------------------------------------------------
  // Driver
  // -------------------------------------------------------------------------
  task automatic send_word(in_word_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_source();
    while (src_q.size() != 0) send_word(src_q.pop_front());
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identifier and number, tab, an operator flushed by another,
    // a two-byte operator at the end of source.
    put_text("Z_9 09\t(<=");
    put_end();
    // Open string holding a newline, an apostrophe and the extreme bytes.
    put_text("\"\n'");
    put_raw(8'hFF);
    put_raw(8'h00);
    put_end();
    // A lone pending operator, then an empty source.
    put_text("-");
    put_end();
    put_end();
    // Identifier closed by a quote, a string, an empty string.
    put_text("a\"b\"\"\"");
    put_end();
    send_source();

    // Random sources with idling; one long output hold early on.
    while (words_sent < RANDOM_WORDS) begin
      if (src_count == 20) hold_req = 1'b1;
      build_random_source();
      send_source();
    end

    // Last part: no idling, then the halt.
    idle_on = 1'b0;
    repeat (10) begin
      build_random_source();
      send_source();
    end
    build_finale();
    send_source();
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.due_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d words in %0d sources, %0d tokens checked, %0d mismatches.",
             sb.noted, src_count, sb.checked, sb.errors);
    $display("Covered all operators, raw string bytes, a %0d-cycle %s %0d.",
             HOLD_CYCLES, "output hold and a halt on error code", finale_err);
    if (sb.errors == 0 && sb.due_tokens.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
